[hdl/nru_pkg.sv]
// shared widths, defaults and the lookup result type of the nru tag store
// no dependencies
package nru_pkg;

    localparam int SET_INDEX_W = 8;
    localparam int TAG_FIELD_W = 20;
    localparam int WAY_FIELD_W = 2;

    localparam int DEF_NUM_SETS  = 256;
    localparam int DEF_NUM_WAYS  = 4;
    localparam int DEF_TAG_WIDTH = 20;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way;
        logic                   dirty_eviction;
    } nru_result_t;

endpackage

[hdl/nru_if.sv]
// valid/ready channels for accesses and lookup results
// depends on nru_pkg
interface nru_req_if;
    import nru_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SET_INDEX_W-1:0] set_index;
    logic [TAG_FIELD_W-1:0] tag;
    logic                   is_write;

    modport source (output valid, output set_index, output tag, output is_write, input ready);
    modport sink   (input valid, input set_index, input tag, input is_write, output ready);
endinterface

interface nru_rsp_if;
    import nru_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
    logic                   dirty_eviction;

    modport source (output valid, output hit, output way, output dirty_eviction, input ready);
    modport sink   (input valid, input hit, input way, input dirty_eviction, output ready);
endinterface

[hdl/nru_tag_ram.sv]
// one row per set holding tags, dirty, valid and nru bits of all ways
// synchronous write, registered read; no dependencies
module nru_tag_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 92
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/nru_way_sel.sv]
// tag compare, nru victim choice and row update for one set
// depends on nru_pkg
module nru_way_sel #(
    parameter int NUM_WAYS  = 4,
    parameter int TAG_WIDTH = 20
) (
    input  logic [NUM_WAYS*(TAG_WIDTH+3)-1:0] row_in,
    input  logic [TAG_WIDTH-1:0]              req_tag,
    input  logic                              is_write,
    output logic [NUM_WAYS*(TAG_WIDTH+3)-1:0] row_out,
    output nru_pkg::nru_result_t              result
);
    import nru_pkg::*;

    localparam int WAY_AW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WAY_XW = (WAY_AW > 2) ? WAY_AW : 2;

    logic [NUM_WAYS*TAG_WIDTH-1:0] tags, tags_new;
    logic [NUM_WAYS-1:0]           valid, dirty, nru, match;
    logic [NUM_WAYS-1:0]           valid_new, dirty_new, nru_new;
    logic [WAY_AW-1:0]             hit_way, vict_way, sel_way;
    logic [WAY_XW-1:0]             way_ext;
    logic                          hit;

    assign {tags, dirty, valid, nru} = row_in;

    always_comb
    begin
        match    = '0;
        hit_way  = '0;
        vict_way = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match[w] = valid[w] && (tags[w*TAG_WIDTH +: TAG_WIDTH] == req_tag);
        end
        // lowest way wins
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_AW'(w);
            end
            if (nru[w])
            begin
                vict_way = WAY_AW'(w);
            end
        end
    end

    assign hit     = |match;
    assign sel_way = hit ? hit_way : vict_way;

    always_comb
    begin
        tags_new  = tags;
        valid_new = valid;
        dirty_new = dirty;
        // no nru bit set on a miss: set them all, way 0 is the victim
        nru_new   = (hit || (|nru)) ? nru : '1;
        nru_new[sel_way] = 1'b0;
        if (hit)
        begin
            dirty_new[sel_way] = dirty[sel_way] | is_write;
        end
        else
        begin
            tags_new[sel_way*TAG_WIDTH +: TAG_WIDTH] = req_tag;
            valid_new[sel_way] = 1'b1;
            dirty_new[sel_way] = is_write;
        end
    end

    assign row_out = {tags_new, dirty_new, valid_new, nru_new};

    assign way_ext               = WAY_XW'(sel_way);
    assign result.hit            = hit;
    assign result.way            = way_ext[WAY_FIELD_W-1:0];
    assign result.dirty_eviction = !hit && valid[sel_way] && dirty[sel_way];

endmodule

[hdl/nru_cache_set_replacement.sv]
// top level of the nru set-associative tag store
// depends on nru_pkg, nru_if, nru_tag_ram, nru_way_sel
//
//   channel | dir | payload                        | transfer when
//   req     | in  | set_index, tag, is_write       | req.valid && req.ready
//   rsp     | out | hit, way, dirty_eviction       | rsp.valid && rsp.ready
//
// each access is a set row read, then compare and write back
// the read-modify-write of one set row through the tag ram sets the rate
// after reset a clearing pass writes NUM_SETS rows, one per cycle, req.ready low
// a new access is taken while a result still waits on rsp
// a stalled rsp holds the write back of the following access
module nru_cache_set_replacement #(
    parameter int NUM_SETS  = nru_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS  = nru_pkg::DEF_NUM_WAYS,
    parameter int TAG_WIDTH = nru_pkg::DEF_TAG_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    nru_req_if.sink   req,
    nru_rsp_if.source rsp
);
    import nru_pkg::*;

    localparam int SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ROW_W    = NUM_WAYS * (TAG_WIDTH + 3);
    localparam int SET_SPAN = 1 << SET_INDEX_W;
    localparam logic [ROW_W-1:0] RESET_ROW = ROW_W'({NUM_WAYS{1'b1}});

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

    state_t             state_reg, state_next;
    logic [SET_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [SET_AW-1:0]  set_reg, set_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic               wr_reg, wr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    nru_result_t        rsp_res_reg, rsp_res_next;

    logic [SET_AW-1:0]  set_lut [SET_SPAN];
    logic               ram_we, ram_re;
    logic [SET_AW-1:0]  ram_waddr, ram_raddr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata, row_new;
    nru_result_t        lookup_res;

    // set index reduced into range
    for (genvar i = 0; i < SET_SPAN; i++)
    begin : g_set_lut
        assign set_lut[i] = SET_AW'(i % NUM_SETS);
    end

    assign ram_raddr = set_lut[req.set_index];

    nru_tag_ram #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_AW),
        .DATA_W (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nru_way_sel #(
        .NUM_WAYS  (NUM_WAYS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_way_sel (
        .row_in   (ram_rdata),
        .req_tag  (tag_reg),
        .is_write (wr_reg),
        .row_out  (row_new),
        .result   (lookup_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        wr_next        = wr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_res_next   = rsp_res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = set_reg;
        ram_wdata      = row_new;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = RESET_ROW;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SET_AW'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ram_re     = 1'b1;
                    set_next   = ram_raddr;
                    tag_next   = TAG_WIDTH'(req.tag);
                    wr_next    = req.is_write;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    ram_we         = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_res_next   = lookup_res;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            set_reg       <= '0;
            tag_reg       <= '0;
            wr_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            set_reg       <= set_next;
            tag_reg       <= tag_next;
            wr_reg        <= wr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_res_reg   <= rsp_res_next;
        end
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = rsp_res_reg.hit;
    assign rsp.way            = rsp_res_reg.way;
    assign rsp.dirty_eviction = rsp_res_reg.dirty_eviction;

    a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result raised without a lookup");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("access taken during clearing pass");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("tag ram written while idle");

    a_writeback_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && ram_we) |=> rsp_valid_reg)
        else $error("write back without a result");

    a_hit_no_eviction: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_res_reg.hit) |-> !rsp_res_reg.dirty_eviction)
        else $error("eviction flagged on a hit");

endmodule
